// File: hdl/tdsc_pkg.sv
// shared types, codes and constants for the doppler search controller
package tdsc_pkg;

   // field widths
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned STAT_W      = 24;
   localparam int unsigned PEAK_W      = 16;
   localparam int unsigned BLOCKS_W    = 16;
   localparam int unsigned SPD_W       = 16;
   localparam int unsigned ADDEND_W    = SPD_W + BLOCKS_W;
   localparam int unsigned K_W         = 8;
   localparam int unsigned BIN_W       = 8;
   localparam int unsigned STEP_W      = 14;
   localparam int unsigned DELTA_W     = BIN_W + STEP_W;
   localparam int unsigned DOP_W       = 23;
   localparam int unsigned STAMP_W     = 64;
   localparam int unsigned REQ_DATA_W  = 56;
   localparam int unsigned RSP_DATA_W  = 112;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 24;

   // result word bit positions
   localparam int unsigned RSP_DONE_BIT   = 0;
   localparam int unsigned RSP_ACQ_BIT    = 1;
   localparam int unsigned RSP_PHASE_LSB  = 2;
   localparam int unsigned RSP_DOP_LSB    = 18;
   localparam int unsigned RSP_STAMP_LSB  = 41;
   localparam int unsigned RSP_SEARCH_BIT = 105;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DWELL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_K_TARGET   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_K_START    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DWELLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_BIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DOP_STEP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPD        = 3'd6;

   // register reset values
   localparam logic [STAT_W-1:0] THRESHOLD_RST  = 24'd5120000;
   localparam logic [K_W-1:0]    K_TARGET_RST   = 8'd8;
   localparam logic [K_W-1:0]    K_START_RST    = 8'd1;
   localparam logic [K_W-1:0]    MAX_DWELLS_RST = 8'd15;
   localparam logic [BIN_W-1:0]  LAST_BIN_RST   = 8'd20;
   localparam logic [STEP_W-1:0] DOP_STEP_RST   = 14'd500;
   localparam logic [SPD_W-1:0]  SPD_RST        = 16'd4000;

   typedef struct packed {
      logic [STAT_W-1:0] threshold;
      logic [K_W-1:0]    k_target;
      logic [K_W-1:0]    k_start;
      logic [K_W-1:0]    max_dwells;
      logic [BIN_W-1:0]  last_bin;
      logic [STEP_W-1:0] doppler_step;
      logic [SPD_W-1:0]  samples_per_dwell;
   } cfg_type;

   // item held in the input register, sample increment already formed
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [STAT_W-1:0]   test_statistic;
      logic [PEAK_W-1:0]   peak_index;
      logic [ADDEND_W-1:0] addend;
   } item_type;

endpackage

// File: hdl/tdsc_csr.sv
// configuration register bank
module tdsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tdsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tdsc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tdsc_pkg::cfg_type                cfg
);

   tdsc_pkg::cfg_type cfg_ff;
   tdsc_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tdsc_pkg::REG_THRESHOLD:  cfg_in.threshold    = csr_wdata;
            tdsc_pkg::REG_K_TARGET:   cfg_in.k_target     = csr_wdata[tdsc_pkg::K_W-1:0];
            tdsc_pkg::REG_K_START:    cfg_in.k_start      = csr_wdata[tdsc_pkg::K_W-1:0];
            tdsc_pkg::REG_MAX_DWELLS: cfg_in.max_dwells   = csr_wdata[tdsc_pkg::K_W-1:0];
            tdsc_pkg::REG_LAST_BIN:   cfg_in.last_bin     = csr_wdata[tdsc_pkg::BIN_W-1:0];
            tdsc_pkg::REG_DOP_STEP:   cfg_in.doppler_step = csr_wdata[tdsc_pkg::STEP_W-1:0];
            tdsc_pkg::REG_SPD:
               cfg_in.samples_per_dwell = csr_wdata[tdsc_pkg::SPD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold         <= tdsc_pkg::THRESHOLD_RST;
         cfg_ff.k_target          <= tdsc_pkg::K_TARGET_RST;
         cfg_ff.k_start           <= tdsc_pkg::K_START_RST;
         cfg_ff.max_dwells        <= tdsc_pkg::MAX_DWELLS_RST;
         cfg_ff.last_bin          <= tdsc_pkg::LAST_BIN_RST;
         cfg_ff.doppler_step      <= tdsc_pkg::DOP_STEP_RST;
         cfg_ff.samples_per_dwell <= tdsc_pkg::SPD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/tdsc_ingress.sv
// input register stage, forms the sample counter increment
module tdsc_ingress (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tdsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [tdsc_pkg::KIND_W-1:0]      req_tuser,
   input  logic [tdsc_pkg::SPD_W-1:0]       samples_per_dwell,
   input  logic                             take,
   output logic                             item_valid,
   output tdsc_pkg::item_type               item
);

   logic                   valid_ff;
   logic                   valid_in;
   tdsc_pkg::item_type     item_ff;
   tdsc_pkg::item_type     item_in;
   logic                   accept;
   logic [tdsc_pkg::BLOCKS_W-1:0] blocks;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;
   assign blocks     = req_tdata[55:40];

   // unpack and precompute the counter increment
   always_comb begin
      item_in.kind           = req_tuser;
      item_in.test_statistic = req_tdata[23:0];
      item_in.peak_index     = req_tdata[39:24];
      unique case (req_tuser)
         tdsc_pkg::KIND_IDLE:  item_in.addend = samples_per_dwell * blocks;
         tdsc_pkg::KIND_DWELL:
            item_in.addend = {{tdsc_pkg::BLOCKS_W{1'b0}}, samples_per_dwell};
         default:              item_in.addend = '0;
      endcase
   end

   // stage occupancy
   always_comb begin
      if (accept)
         valid_in = 1'b1;
      else if (take)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: hdl/tdsc_detector.sv
// tong detector state, bin stepping and result register
module tdsc_detector (
   input  logic                             clock,
   input  logic                             reset,
   input  tdsc_pkg::cfg_type                cfg,
   input  logic                             item_valid,
   input  tdsc_pkg::item_type               item,
   output logic                             take,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tdsc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // search state
   logic                           active_ff, active_in;
   logic [tdsc_pkg::K_W-1:0]       k_ff, k_in;
   logic [tdsc_pkg::K_W-1:0]       dwell_ff, dwell_in;
   logic [tdsc_pkg::BIN_W-1:0]     bin_ff, bin_in;
   logic [tdsc_pkg::DOP_W-1:0]     dop_ff, dop_in;
   logic [tdsc_pkg::STAMP_W-1:0]   counter_ff, counter_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tdsc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // per-item working values
   logic                           done, acq;
   logic [tdsc_pkg::PEAK_W-1:0]    phase;
   logic [tdsc_pkg::DOP_W-1:0]     dop_out;
   logic [tdsc_pkg::K_W-1:0]       k_inc, k_dec, dwell_sat;
   logic [tdsc_pkg::BIN_W:0]       bin_nx;
   logic [tdsc_pkg::DELTA_W-1:0]   delta;
   logic [tdsc_pkg::DOP_W-1:0]     delta_ext;
   logic [tdsc_pkg::STAMP_W-1:0]   counter_add;

   assign take = item_valid && (!rsp_valid_ff || rsp_tready);

   assign k_inc       = k_ff + 8'd1;
   assign k_dec       = (k_ff != '0) ? k_ff - 8'd1 : '0;
   assign dwell_sat   = (dwell_ff == 8'hFF) ? dwell_ff : dwell_ff + 8'd1;
   assign bin_nx      = {1'b0, bin_ff} + 9'd1;
   assign delta       = bin_nx[tdsc_pkg::BIN_W-1:0] * cfg.doppler_step;
   assign delta_ext   = {1'b0, delta};
   assign counter_add = counter_ff
                      + {{(tdsc_pkg::STAMP_W-tdsc_pkg::ADDEND_W){1'b0}}, item.addend};

   // next state and result for the held item
   always_comb begin
      active_in  = active_ff;
      k_in       = k_ff;
      dwell_in   = dwell_ff;
      bin_in     = bin_ff;
      dop_in     = dop_ff;
      counter_in = counter_ff;
      done       = 1'b0;
      acq        = 1'b0;
      phase      = '0;
      dop_out    = dop_ff;
      unique case (item.kind)
         tdsc_pkg::KIND_START: begin
            active_in = 1'b1;
            k_in      = cfg.k_start;
            dwell_in  = '0;
            bin_in    = '0;
            dop_in    = '0;
            dop_out   = '0;
         end
         tdsc_pkg::KIND_IDLE: begin
            counter_in = counter_add;
         end
         tdsc_pkg::KIND_DWELL: begin
            if (active_ff) begin
               counter_in = counter_add;
               if (item.test_statistic > cfg.threshold) begin
                  // hit: K goes up, target reached ends the search
                  if (k_inc == cfg.k_target) begin
                     done      = 1'b1;
                     acq       = 1'b1;
                     phase     = item.peak_index;
                     active_in = 1'b0;
                     k_in      = cfg.k_start;
                     dwell_in  = '0;
                     bin_in    = '0;
                     dop_in    = '0;
                  end else begin
                     k_in     = k_inc;
                     dwell_in = dwell_sat;
                  end
               end else if (k_dec == '0 || dwell_ff > cfg.max_dwells) begin
                  // bin abandoned: step to the next bin or give up
                  k_in     = cfg.k_start;
                  dwell_in = '0;
                  if (bin_nx > {1'b0, cfg.last_bin}) begin
                     done      = 1'b1;
                     active_in = 1'b0;
                     bin_in    = '0;
                     dop_in    = '0;
                  end else begin
                     bin_in  = bin_nx[tdsc_pkg::BIN_W-1:0];
                     dop_in  = bin_nx[0] ? dop_ff + delta_ext : dop_ff - delta_ext;
                     dop_out = dop_in;
                  end
               end else begin
                  k_in     = k_dec;
                  dwell_in = dwell_sat;
               end
            end
         end
         default: ;
      endcase
   end

   // pack the result word, done at bit 0
   assign rsp_data_in = {6'b0, active_in, counter_in, dop_out, phase, acq, done};

   always_comb begin
      if (take)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         k_ff         <= tdsc_pkg::K_START_RST;
         dwell_ff     <= '0;
         bin_ff       <= '0;
         dop_ff       <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            active_ff  <= active_in;
            k_ff       <= k_in;
            dwell_ff   <= dwell_in;
            bin_ff     <= bin_in;
            dop_ff     <= dop_in;
            counter_ff <= counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/tong_doppler_search_controller_top.sv
// top level of the tong detector doppler search controller
//
// Request channel (req_): one transfer per command. req_tuser carries the kind
// (start search, dwell result, idle blocks); req_tdata carries the test
// statistic, peak index and idle block count. Response channel (rsp_): exactly
// one transfer per request, in order, with done/acquired flags, code phase,
// doppler in hertz, the 64-bit sample count and the searching flag.
// Configuration: csr_we writes csr_wdata into register csr_index;
// write only while no request is in flight.
// Path: a request transfer is captured in the input register, and its
// response is loaded into the output register once that register is empty
// or being read; rsp_tvalid is driven straight from the output register.
// Throughput: one request per cycle while rsp_tready stays high; the sample
// counter update (one 64-bit add) and the bin step (one 8x14 multiply and
// add) are both combinational.
// When the receiver holds rsp_tready low both registers hold their contents
// and req_tready drops once the input register is full.
// Reset clears both stages, stops the search and returns all registers to
// their defaults and the sample counter to zero.
module tong_doppler_search_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // test_statistic[23:0], peak_index[39:24], block_count[55:40]
   input  logic [tdsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[1:0]
   input  logic [tdsc_pkg::KIND_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // done_res[0], acquired[1], code_phase[17:2], doppler_hz[40:18],
   // sample_count[104:41], searching[105], zero fill[111:106]
   output logic [tdsc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [tdsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tdsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tdsc_pkg::cfg_type  cfg;
   tdsc_pkg::item_type item;
   logic               item_valid;
   logic               take;

   tdsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tdsc_ingress u_ingress (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .samples_per_dwell (cfg.samples_per_dwell),
      .take              (take),
      .item_valid        (item_valid),
      .item              (item)
   );

   tdsc_detector u_detector (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: hdl/tdsc_checker.sv
// port-level checks on the search controller, bound to the top level
module tdsc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tdsc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // acquisition only on a finishing response
   a_acq_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[tdsc_pkg::RSP_ACQ_BIT] |-> rsp_tdata[tdsc_pkg::RSP_DONE_BIT])
      else $error("acquired without done");

   // a finished search is no longer active
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[tdsc_pkg::RSP_DONE_BIT]
         |-> !rsp_tdata[tdsc_pkg::RSP_SEARCH_BIT])
      else $error("searching still set on finish");

   // code phase only reported with acquisition
   a_phase_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[tdsc_pkg::RSP_ACQ_BIT]
         |-> rsp_tdata[tdsc_pkg::RSP_PHASE_LSB +: tdsc_pkg::PEAK_W] == '0)
      else $error("code phase without acquisition");

   // no response right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind tong_doppler_search_controller_top tdsc_checker u_tdsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/tong_doppler_search_controller_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the tong detector doppler search controller
module tong_doppler_search_controller_top_tb;
   import tdsc_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_PAD      = 5;
   localparam int unsigned NUM_PHASES     = 12;

   // one expected response transfer
   typedef struct packed {
      logic              done;
      logic              acquired;
      logic [PEAK_W-1:0] code_phase;
      logic [DOP_W-1:0]  doppler;
      logic [STAMP_W-1:0] stamp;
      logic              searching;
   } search_report_type;

   // search state mirror and ordered store of expected reports
   class search_scoreboard_type;
      logic [STAT_W-1:0]  threshold;
      logic [K_W-1:0]     k_target;
      logic [K_W-1:0]     k_start;
      logic [K_W-1:0]     max_dwells;
      logic [BIN_W-1:0]   last_bin;
      logic [STEP_W-1:0]  doppler_step;
      logic [SPD_W-1:0]   samples_per_dwell;

      logic               active;
      logic [K_W-1:0]     k_count;
      logic [K_W-1:0]     dwell_count;
      logic [BIN_W:0]     bin_index;
      logic [DOP_W-1:0]   doppler_now;
      logic [STAMP_W-1:0] sample_counter;

      search_report_type  expected_reports[$];
      int unsigned        errors;

      function new();
         threshold         = THRESHOLD_RST;
         k_target          = K_TARGET_RST;
         k_start           = K_START_RST;
         max_dwells        = MAX_DWELLS_RST;
         last_bin          = LAST_BIN_RST;
         doppler_step      = DOP_STEP_RST;
         samples_per_dwell = SPD_RST;
         sample_counter    = '0;
         errors            = 0;
         end_search();
      endfunction

      // both finishes and a start return the bin search to its origin
      function void end_search();
         active      = 1'b0;
         k_count     = k_start;
         dwell_count = '0;
         bin_index   = '0;
         doppler_now = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_THRESHOLD:  threshold         = value[STAT_W-1:0];
            REG_K_TARGET:   k_target          = value[K_W-1:0];
            REG_K_START:    k_start           = value[K_W-1:0];
            REG_MAX_DWELLS: max_dwells        = value[K_W-1:0];
            REG_LAST_BIN:   last_bin          = value[BIN_W-1:0];
            REG_DOP_STEP:   doppler_step      = value[STEP_W-1:0];
            REG_SPD:        samples_per_dwell = value[SPD_W-1:0];
            default: ;
         endcase
      endfunction

      // predict the report for one accepted request transfer
      function void note_request(logic [KIND_W-1:0] kind, logic [STAT_W-1:0] stat,
                                 logic [PEAK_W-1:0] peak, logic [BLOCKS_W-1:0] blocks);
         search_report_type rep;
         logic [31:0]       delta;
         rep = '0;
         if (kind == KIND_START) begin
            end_search();
            active = 1'b1;
         end else if (kind == KIND_IDLE) begin
            sample_counter += 64'(samples_per_dwell) * 64'(blocks);
         end
         rep.doppler = doppler_now;

         if (kind == KIND_DWELL && active) begin
            sample_counter += 64'(samples_per_dwell);
            if (stat > threshold) begin
               // hit: K up, wraps at 8 bits
               k_count = k_count + 8'd1;
               if (k_count == k_target) begin
                  rep.done       = 1'b1;
                  rep.acquired   = 1'b1;
                  rep.code_phase = peak;
                  rep.doppler    = doppler_now;
                  end_search();
               end else if (dwell_count != 8'hFF) begin
                  dwell_count++;
               end
            end else begin
               // miss: K down, floor at zero
               if (k_count != 8'd0) k_count--;
               if (k_count == 8'd0 || dwell_count > max_dwells) begin
                  k_count     = k_start;
                  dwell_count = '0;
                  bin_index++;
                  if (bin_index > last_bin) begin
                     rep.done    = 1'b1;
                     rep.doppler = doppler_now;
                     end_search();
                  end else begin
                     // zig-zag: odd bins step up, even bins step down
                     delta = bin_index * doppler_step;
                     if (bin_index[0]) doppler_now = doppler_now + delta[DOP_W-1:0];
                     else doppler_now = doppler_now - delta[DOP_W-1:0];
                     rep.doppler = doppler_now;
                  end
               end else if (dwell_count != 8'hFF) begin
                  dwell_count++;
               end
            end
         end

         rep.stamp     = sample_counter;
         rep.searching = active;
         expected_reports.push_back(rep);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare one response transfer with the oldest expected report
      function void check_response(logic [RSP_DATA_W-1:0] word);
         search_report_type rep;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, word);
            errors++;
            return;
         end
         rep = expected_reports.pop_front();
         compare_field("done_res", rep.done, word[RSP_DONE_BIT]);
         compare_field("acquired", rep.acquired, word[RSP_ACQ_BIT]);
         compare_field("code_phase", rep.code_phase, word[RSP_PHASE_LSB +: PEAK_W]);
         compare_field("doppler_hz", rep.doppler, word[RSP_DOP_LSB +: DOP_W]);
         compare_field("sample_count", rep.stamp, word[RSP_STAMP_LSB +: STAMP_W]);
         compare_field("searching", rep.searching, word[RSP_SEARCH_BIT]);
      endfunction

      function int unsigned outstanding();
         return expected_reports.size();
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [KIND_W-1:0]       req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   search_scoreboard_type sb = new();
   bit               no_idle    = 1'b0;
   int unsigned      items_sent = 0;
   int unsigned      stall_cycles = 0;

   tong_doppler_search_controller_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on cycles without any transfer or register write
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: random ready gaps, check every transfer
   initial begin
      int unsigned gap;
      while (reset) @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata);
         @(negedge clock);
      end
   end

   // one request transfer, preceded by a random valid gap
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [STAT_W-1:0] stat,
                            input logic [PEAK_W-1:0] peak, input logic [BLOCKS_W-1:0] blocks);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (!(kind == KIND_UNUSED || (kind == KIND_DWELL && !sb.active))) items_sent++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {blocks, peak, stat};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, stat, peak, blocks);
   endtask

   // stop sending and wait until every report has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // test statistic on the wanted side of the threshold where one exists, edges favored
   function automatic logic [STAT_W-1:0] pick_stat(input bit hit);
      logic [STAT_W-1:0] thr;
      thr = sb.threshold;
      if (thr == 24'hFFFFFF)
         return $urandom;
      if (hit)
         return ($urandom_range(0, 3) == 0) ? thr + 24'd1 : $urandom_range(thr + 1, 24'hFFFFFF);
      return ($urandom_range(0, 3) == 0) ? thr : $urandom_range(0, thr);
   endfunction

   function automatic logic [BLOCKS_W-1:0] pick_blocks();
      case ($urandom_range(0, 15))
         0:       return 16'hFFFF;
         1, 2:    return $urandom;
         default: return $urandom_range(0, 8);
      endcase
   endfunction

   // register setting for each random phase: reset defaults first, then extremes
   task automatic apply_setting(input int unsigned phase);
      logic [CSR_DATA_W-1:0] thr, kt, ks, md, lb, st, spd;
      thr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 24'hFFFFFF);
      kt  = $urandom_range(1, 12);
      ks  = $urandom_range(1, kt);
      md  = $urandom_range(0, 20);
      lb  = $urandom_range(0, 30);
      st  = $urandom_range(1, 10000);
      spd = $urandom_range(1, 65535);
      case (phase)
         0: begin
            thr = THRESHOLD_RST; kt = K_TARGET_RST; ks = K_START_RST; md = MAX_DWELLS_RST;
            lb = LAST_BIN_RST; st = DOP_STEP_RST; spd = SPD_RST;
         end
         1: begin
            thr = 0; kt = 1; ks = 1; md = 0; lb = 0; st = 1; spd = 1;
         end
         2: begin
            thr = 24'hFFFFFF; kt = 255; ks = 255; md = 255; lb = 255; st = 10000; spd = 65535;
         end
         // long random walk of K so the dwell count saturates
         3: begin
            kt = 255; ks = 128; md = 255; lb = $urandom_range(0, 255);
         end
         4: begin
            ks = $urandom_range(1, 255); kt = $urandom_range(1, 255); lb = 255; st = 10000;
         end
         default: ;
      endcase
      csr_write(REG_THRESHOLD, thr);
      csr_write(REG_K_TARGET, kt);
      csr_write(REG_K_START, ks);
      csr_write(REG_MAX_DWELLS, md);
      csr_write(REG_LAST_BIN, lb);
      csr_write(REG_DOP_STEP, st);
      csr_write(REG_SPD, spd);
      csr_release();
   endtask

   // one search: start, then dwells mixed with idle blocks and noise
   task automatic run_search(input int unsigned hit_pct, input int unsigned cap);
      int unsigned n;
      int unsigned r;
      logic [KIND_W-1:0] k;
      send_item(KIND_START, $urandom, $urandom, $urandom);
      n = 1;
      while (sb.active && n < cap) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            k = $urandom_range(0, 3);
            send_item(k, $urandom, $urandom, $urandom);
         end else if (r < 10) begin
            send_item(KIND_IDLE, $urandom, $urandom, pick_blocks());
         end else begin
            send_item(KIND_DWELL, pick_stat($urandom_range(0, 99) < hit_pct), $urandom,
                      $urandom);
         end
         n++;
      end
   endtask

   // main sequence
   initial begin
      int unsigned budget;
      int unsigned hit_pct;
      int unsigned search_cap;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unused kind, idle extremes, dwell while idle
      send_item(KIND_UNUSED, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_IDLE, 24'h000000, 16'h0000, 16'hFFFF);
      send_item(KIND_DWELL, 24'hFFFFFF, 16'hFFFF, 16'h0000);
      // miss at threshold steps the bin, then hits up to acquisition
      send_item(KIND_START, 24'h000000, 16'h0000, 16'h0000);
      send_item(KIND_DWELL, THRESHOLD_RST, 16'h1234, 16'h0000);
      repeat (6) send_item(KIND_DWELL, THRESHOLD_RST + 24'd1, 16'h0000, 16'h0000);
      send_item(KIND_DWELL, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      // restart while active, unused kind and idle while active, miss at zero stat
      send_item(KIND_START, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_START, 24'h000000, 16'h0000, 16'h0000);
      send_item(KIND_UNUSED, 24'h000000, 16'h0000, 16'h0000);
      send_item(KIND_IDLE, 24'hFFFFFF, 16'hFFFF, 16'h0001);
      send_item(KIND_DWELL, 24'h000000, 16'h0000, 16'h0000);
      drain();

      // K overflow, miss at K zero, failure past the last bin
      csr_write(REG_K_START, 8'd255);
      csr_write(REG_K_TARGET, 8'd1);
      csr_write(REG_LAST_BIN, 8'd0);
      csr_release();
      send_item(KIND_START, 24'h000000, 16'h0000, 16'h0000);
      send_item(KIND_DWELL, 24'hFFFFFF, 16'h5555, 16'h0000);
      send_item(KIND_DWELL, 24'h000000, 16'hAAAA, 16'h0000);
      send_item(KIND_START, 24'h000000, 16'h0000, 16'h0000);
      send_item(KIND_DWELL, 24'hFFFFFF, 16'h0F0F, 16'h0000);
      send_item(KIND_DWELL, 24'hFFFFFF, 16'hF0F0, 16'h0000);

      // random phases, each under its own register setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         apply_setting(p);
         no_idle = (p % 4 == 2);
         budget  = items_sent + ((p == 3) ? 320 : 95);
         while (items_sent < budget) begin
            case ($urandom_range(0, 4))
               0:       hit_pct = 0;
               1:       hit_pct = 35;
               2:       hit_pct = 65;
               3:       hit_pct = 85;
               default: hit_pct = 100;
            endcase
            if (p == 3) hit_pct = 50;
            // a search never runs past the phase budget
            search_cap = (p == 3) ? 400 : 120;
            if (search_cap > budget - items_sent) search_cap = budget - items_sent;
            run_search(hit_pct, search_cap);
            if ($urandom_range(0, 3) == 0)
               send_item(KIND_IDLE, $urandom, $urandom, pick_blocks());
            if ($urandom_range(0, 7) == 0)
               send_item(KIND_DWELL, $urandom, $urandom, $urandom);
         end
      end
      no_idle = 1'b0;
      drain();

      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: sim.f
hdl/tdsc_pkg.sv
hdl/tdsc_csr.sv
hdl/tdsc_ingress.sv
hdl/tdsc_detector.sv
hdl/tong_doppler_search_controller_top.sv
hdl/tdsc_checker.sv
test/tong_doppler_search_controller_top_tb.sv
